[rtl/usd_pkg.sv]
// ----------------------------------------------------------------------------
// usd_pkg
// Shared types and constants for the UTF-8 stream decoder.
// ----------------------------------------------------------------------------
package usd_pkg;

    localparam int CP_W     = 31;
    localparam int ASCII_W  = 7;
    localparam int QDEPTH   = 4;
    localparam int QPTR_W   = $clog2(QDEPTH);
    localparam int QCNT_W   = $clog2(QDEPTH + 1);

    localparam logic [ASCII_W-1:0] BAD_CHAR = 7'h3F;

    localparam logic [1:0] CONT_TAG = 2'b10;

    // Results of one input byte: the first one always, the second one when two is set.
    typedef struct packed {
        logic                  two;
        logic [CP_W-1:0]       cp0;
        logic [ASCII_W-1:0]    cp1;
    } usd_packet_t;

    typedef struct packed {
        logic        valid;
        usd_packet_t packet;
    } usd_head_t;

endpackage

[rtl/usd_front.sv]
// ----------------------------------------------------------------------------
// usd_front
// Accepts input bytes, tracks the pending sequence and builds result packets.
// ----------------------------------------------------------------------------
module usd_front (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [7:0]            s_byte_in,
    input  logic                  s_end_of_text,
    input  logic                  q_full,
    output logic                  q_push,
    output usd_pkg::usd_packet_t  q_packet
);

    logic [usd_pkg::CP_W-1:0] partial_reg, partial_next;
    logic [2:0]               remain_reg, remain_next;
    logic                     skip_reg, skip_next;
    logic                     accept;
    logic [1:0]               count;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;
    assign q_push  = accept && (count != 2'd0);

    always_comb begin
        logic [usd_pkg::CP_W-1:0] pv;
        logic [2:0]               rem;
        logic                     skip;
        logic [1:0]               n;
        logic [usd_pkg::CP_W-1:0] cp0;
        logic [usd_pkg::ASCII_W-1:0] cp1;
        logic                     emit_bad;

        pv   = partial_reg;
        rem  = remain_reg;
        skip = skip_reg;
        n    = 2'd0;
        cp0  = '0;
        cp1  = '0;
        emit_bad = 1'b0;

        if (s_byte_in[7:6] == usd_pkg::CONT_TAG) begin
            if (rem != 3'd0) begin
                pv  = {pv[usd_pkg::CP_W-7:0], s_byte_in[5:0]};
                rem = rem - 3'd1;
                if (rem == 3'd0) begin
                    cp0 = pv;
                    n   = 2'd1;
                    pv  = '0;
                end
            end else if (!skip) begin
                cp0  = {{(usd_pkg::CP_W-usd_pkg::ASCII_W){1'b0}}, usd_pkg::BAD_CHAR};
                n    = 2'd1;
                skip = 1'b1;
            end
        end else begin
            skip = 1'b0;
            if (rem != 3'd0) begin
                cp0 = {{(usd_pkg::CP_W-usd_pkg::ASCII_W){1'b0}}, usd_pkg::BAD_CHAR};
                n   = 2'd1;
                rem = 3'd0;
                pv  = '0;
            end
            if (!s_byte_in[7]) begin
                if (n == 2'd0) begin
                    cp0 = {{(usd_pkg::CP_W-8){1'b0}}, s_byte_in};
                    n   = 2'd1;
                end else begin
                    cp1 = s_byte_in[6:0];
                    n   = 2'd2;
                end
            end else if (!s_byte_in[5]) begin
                pv  = {{(usd_pkg::CP_W-5){1'b0}}, s_byte_in[4:0]};
                rem = 3'd1;
            end else if (!s_byte_in[4]) begin
                pv  = {{(usd_pkg::CP_W-4){1'b0}}, s_byte_in[3:0]};
                rem = 3'd2;
            end else if (!s_byte_in[3]) begin
                pv  = {{(usd_pkg::CP_W-3){1'b0}}, s_byte_in[2:0]};
                rem = 3'd3;
            end else if (!s_byte_in[2]) begin
                pv  = {{(usd_pkg::CP_W-2){1'b0}}, s_byte_in[1:0]};
                rem = 3'd4;
            end else begin
                pv  = {{(usd_pkg::CP_W-1){1'b0}}, s_byte_in[0]};
                rem = 3'd5;
            end
        end

        if (s_end_of_text) begin
            emit_bad = (rem != 3'd0);
            pv   = '0;
            rem  = 3'd0;
            skip = 1'b0;
        end

        if (emit_bad) begin
            if (n == 2'd0) begin
                cp0 = {{(usd_pkg::CP_W-usd_pkg::ASCII_W){1'b0}}, usd_pkg::BAD_CHAR};
                n   = 2'd1;
            end else begin
                cp1 = usd_pkg::BAD_CHAR;
                n   = 2'd2;
            end
        end

        partial_next    = pv;
        remain_next     = rem;
        skip_next       = skip;
        count           = n;
        q_packet.two    = (n == 2'd2);
        q_packet.cp0    = cp0;
        q_packet.cp1    = cp1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            partial_reg <= '0;
            remain_reg  <= 3'd0;
            skip_reg    <= 1'b0;
        end else if (accept) begin
            partial_reg <= partial_next;
            remain_reg  <= remain_next;
            skip_reg    <= skip_next;
        end
    end

endmodule

[rtl/usd_queue.sv]
// ----------------------------------------------------------------------------
// usd_queue
// Short packet queue between the decode front and the output back end.
// ----------------------------------------------------------------------------
module usd_queue (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push,
    input  usd_pkg::usd_packet_t  push_packet,
    output logic                  full,
    input  logic                  pop,
    output usd_pkg::usd_head_t    head
);

    usd_pkg::usd_packet_t            mem [usd_pkg::QDEPTH];
    logic [usd_pkg::QPTR_W-1:0]      wr_ptr_reg, rd_ptr_reg;
    logic [usd_pkg::QCNT_W-1:0]      count_reg, count_next;

    assign full        = (count_reg == usd_pkg::QCNT_W'(usd_pkg::QDEPTH));
    assign head.valid  = (count_reg != '0);
    assign head.packet = mem[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        case ({push, pop})
            2'b10:   count_next = count_reg + usd_pkg::QCNT_W'(1);
            2'b01:   count_next = count_reg - usd_pkg::QCNT_W'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_packet;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + usd_pkg::QPTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + usd_pkg::QPTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

endmodule

[rtl/usd_back.sv]
// ----------------------------------------------------------------------------
// usd_back
// Splits queued packets into single results and drives the output register.
// ----------------------------------------------------------------------------
module usd_back (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  usd_pkg::usd_head_t          head,
    output logic                        pop,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [usd_pkg::CP_W-1:0]    m_code_point,
    output logic                        m_last_in_run
);

    logic                       valid_reg, valid_next;
    logic [usd_pkg::CP_W-1:0]   cp_reg, cp_next;
    logic                       last_reg, last_next;
    logic                       second_reg, second_next;
    logic                       load;

    assign m_valid       = valid_reg;
    assign m_code_point  = cp_reg;
    assign m_last_in_run = last_reg;
    assign load          = !valid_reg || m_ready;

    always_comb begin
        valid_next  = valid_reg;
        cp_next     = cp_reg;
        last_next   = last_reg;
        second_next = second_reg;
        pop         = 1'b0;
        if (load) begin
            valid_next = head.valid;
            if (head.valid) begin
                if (second_reg) begin
                    cp_next     = {{(usd_pkg::CP_W-usd_pkg::ASCII_W){1'b0}}, head.packet.cp1};
                    last_next   = 1'b1;
                    second_next = 1'b0;
                    pop         = 1'b1;
                end else if (head.packet.two) begin
                    cp_next     = head.packet.cp0;
                    last_next   = 1'b0;
                    second_next = 1'b1;
                end else begin
                    cp_next     = head.packet.cp0;
                    last_next   = 1'b1;
                    pop         = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg  <= 1'b0;
            second_reg <= 1'b0;
        end else begin
            valid_reg  <= valid_next;
            second_reg <= second_next;
        end
    end

    always_ff @(posedge aclk) begin
        cp_reg   <= cp_next;
        last_reg <= last_next;
    end

endmodule

[rtl/utf8_stream_decoder.sv]
// ----------------------------------------------------------------------------
// utf8_stream_decoder
// Byte-serial decoder for six-byte UTF-8 with code points up to 31 bits.
// ----------------------------------------------------------------------------
// One byte is accepted per cycle while the four-entry packet queue has room.
// A byte yields zero, one or two results; the output register sends one result
// per cycle while m_ready is high, so the two results of a byte go out one after
// the other and m_last_in_run marks the final result of each byte. Malformed
// input gives 0x3F. A result passes the queue entry, then the output register.
module utf8_stream_decoder (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_byte_in,
    input  logic        s_end_of_text,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [30:0] m_code_point,
    output logic        m_last_in_run
);

    logic                  q_full;
    logic                  q_push;
    logic                  q_pop;
    usd_pkg::usd_packet_t  q_packet;
    usd_pkg::usd_head_t    q_head;

    usd_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_byte_in     (s_byte_in),
        .s_end_of_text (s_end_of_text),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_packet      (q_packet)
    );

    usd_queue u_queue (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .push        (q_push),
        .push_packet (q_packet),
        .full        (q_full),
        .pop         (q_pop),
        .head        (q_head)
    );

    usd_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .head          (q_head),
        .pop           (q_pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_code_point  (m_code_point),
        .m_last_in_run (m_last_in_run)
    );

endmodule
